// ===== sv/fsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants for the flux stream decoder: word layouts,
// parser phase codes, packet header codes and field widths.
// ----------------------------------------------------------------------------
package fsd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned OVF_W   = 16;                // overflow in units of 0x10000
   localparam int unsigned SUM_W   = OVF_W + RAW_W;     // 32-bit unscaled interval
   localparam int unsigned SCALE_W = 10;
   localparam int unsigned VALUE_W = SUM_W + SCALE_W;   // 42-bit scaled interval
   localparam int unsigned SKIP_W  = 17;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd1000;
   localparam logic [OVF_W-1:0]   OVF_LIMIT   = 16'hFFFF;  // 0xFFFF0000 saturation

   // packet header codes
   localparam logic [BYTE_W-1:0] HDR_FLUX2_MAX = 8'h07;
   localparam logic [BYTE_W-1:0] HDR_NOP2      = 8'h09;
   localparam logic [BYTE_W-1:0] HDR_NOP3      = 8'h0A;
   localparam logic [BYTE_W-1:0] HDR_OVF16     = 8'h0B;
   localparam logic [BYTE_W-1:0] HDR_FLUX3     = 8'h0C;
   localparam logic [BYTE_W-1:0] HDR_OOB       = 8'h0D;
   localparam logic [BYTE_W-1:0] HDR_FLUX1_MIN = 8'h0E;
   localparam logic [BYTE_W-1:0] OOB_END       = 8'h0D;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_F2_LOW   = 4'd1,
      PH_F3_HIGH  = 4'd2,
      PH_F3_LOW   = 4'd3,
      PH_SKIP     = 4'd4,
      PH_OOB_TYPE = 4'd5,
      PH_OOB_SZLO = 4'd6,
      PH_OOB_SZHI = 4'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [41:0] flux_value;
      logic        flux_valid;
      logic        stream_end;
   } rsp_word_type;

   // parser stage result, unscaled
   typedef struct packed {
      logic [SUM_W-1:0] flux_sum;
      logic             flux_valid;
      logic             stream_end;
   } parse_word_type;

   // stage handshake towards a pipeline stage
   typedef struct packed {
      logic src_valid;  // upstream stage holds a word
      logic advance;    // this stage may load
   } stage_ctl_type;

endpackage

// ===== sv/fsd_parser.sv =====
// ----------------------------------------------------------------------------
// fsd_parser
// Packet parser: decodes one held stream byte against the parse state and
// presents the unscaled interval and end-of-stream flag to the result stage.
// ----------------------------------------------------------------------------
module fsd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  fsd_pkg::stage_ctl_type  ctl,
   input  fsd_pkg::req_word_type   byte_word,
   output logic                    par_valid,
   output fsd_pkg::parse_word_type par_word
);

   fsd_pkg::phase_type             phase_ff, phase_in;
   logic [fsd_pkg::OVF_W-1:0]      ovf_ff, ovf_in;
   logic [fsd_pkg::BYTE_W-1:0]     partial_ff, partial_in;
   logic [fsd_pkg::SKIP_W-1:0]     skip_ff, skip_in;
   logic [fsd_pkg::BYTE_W-1:0]     kind_ff, kind_in;

   logic [fsd_pkg::BYTE_W-1:0]     b;
   logic [fsd_pkg::SKIP_W-1:0]     skip_dec;
   logic [fsd_pkg::RAW_W-1:0]      raw;
   logic                           flux_hit;
   logic                           oob_end_hit;
   logic                           end_hit;
   logic                           take;

   assign b        = byte_word.data_byte;
   assign take     = ctl.src_valid && ctl.advance;
   assign skip_dec = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         fsd_pkg::PH_F2_LOW:   phase_in = fsd_pkg::PH_IDLE;
         fsd_pkg::PH_F3_HIGH:  phase_in = fsd_pkg::PH_F3_LOW;
         fsd_pkg::PH_F3_LOW:   phase_in = fsd_pkg::PH_IDLE;
         fsd_pkg::PH_SKIP: begin
            if (skip_dec == '0) phase_in = fsd_pkg::PH_IDLE;
         end
         fsd_pkg::PH_OOB_TYPE: phase_in = fsd_pkg::PH_OOB_SZLO;
         fsd_pkg::PH_OOB_SZLO: phase_in = fsd_pkg::PH_OOB_SZHI;
         fsd_pkg::PH_OOB_SZHI: begin
            if (kind_ff == fsd_pkg::OOB_END || {b, partial_ff} == '0)
               phase_in = fsd_pkg::PH_IDLE;
            else
               phase_in = fsd_pkg::PH_SKIP;
         end
         // idle, and any unused code
         default: begin
            phase_in = fsd_pkg::PH_IDLE;
            if (b <= fsd_pkg::HDR_FLUX2_MAX) phase_in = fsd_pkg::PH_F2_LOW;
            else if (b == fsd_pkg::HDR_NOP2 || b == fsd_pkg::HDR_NOP3)
               phase_in = fsd_pkg::PH_SKIP;
            else if (b == fsd_pkg::HDR_FLUX3) phase_in = fsd_pkg::PH_F3_HIGH;
            else if (b == fsd_pkg::HDR_OOB) phase_in = fsd_pkg::PH_OOB_TYPE;
         end
      endcase
      if (byte_word.last_byte || oob_end_hit) phase_in = fsd_pkg::PH_IDLE;
   end

   // datapath outputs of the decode step
   always_comb begin
      ovf_in      = ovf_ff;
      partial_in  = partial_ff;
      skip_in     = skip_ff;
      kind_in     = kind_ff;
      raw         = '0;
      flux_hit    = 1'b0;
      oob_end_hit = 1'b0;
      unique case (phase_ff)
         fsd_pkg::PH_F2_LOW: begin
            raw      = {5'd0, partial_ff[2:0], b};
            flux_hit = 1'b1;
         end
         fsd_pkg::PH_F3_HIGH: partial_in = b;
         fsd_pkg::PH_F3_LOW: begin
            raw      = {partial_ff, b};
            flux_hit = 1'b1;
         end
         fsd_pkg::PH_SKIP:     skip_in = skip_dec;
         fsd_pkg::PH_OOB_TYPE: kind_in = b;
         fsd_pkg::PH_OOB_SZLO: partial_in = b;
         fsd_pkg::PH_OOB_SZHI: begin
            if (kind_ff == fsd_pkg::OOB_END) oob_end_hit = 1'b1;
            else if ({b, partial_ff} != '0) skip_in = {1'b0, b, partial_ff};
         end
         default: begin
            if (b <= fsd_pkg::HDR_FLUX2_MAX) begin
               partial_in = b;
            end else if (b >= fsd_pkg::HDR_FLUX1_MIN) begin
               raw      = {8'd0, b};
               flux_hit = 1'b1;
            end else if (b == fsd_pkg::HDR_NOP2) begin
               skip_in = fsd_pkg::SKIP_W'(1);
            end else if (b == fsd_pkg::HDR_NOP3) begin
               skip_in = fsd_pkg::SKIP_W'(2);
            end else if (b == fsd_pkg::HDR_OVF16) begin
               if (ovf_ff != fsd_pkg::OVF_LIMIT) ovf_in = ovf_ff + 1'b1;
            end
         end
      endcase
      if (flux_hit) ovf_in = '0;
      // end of stream clears the whole parser
      if (byte_word.last_byte || oob_end_hit) begin
         ovf_in     = '0;
         partial_in = '0;
         skip_in    = '0;
         kind_in    = '0;
      end
   end

   assign end_hit = byte_word.last_byte || oob_end_hit;

   // parse state, updated as a byte leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fsd_pkg::PH_IDLE;
         ovf_ff     <= '0;
         partial_ff <= '0;
         skip_ff    <= '0;
         kind_ff    <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         ovf_ff     <= ovf_in;
         partial_ff <= partial_in;
         skip_ff    <= skip_in;
         kind_ff    <= kind_in;
      end
   end

   // parse result towards the result stage
   assign par_valid           = ctl.src_valid && (flux_hit || end_hit);
   assign par_word.flux_sum   = flux_hit ? {ovf_ff, raw} : '0;
   assign par_word.flux_valid = flux_hit;
   assign par_word.stream_end = end_hit;

endmodule

// ===== sv/fsd_scaler.sv =====
// ----------------------------------------------------------------------------
// fsd_scaler
// Scales the unscaled interval by the output factor and holds the result
// word for the output channel.
// ----------------------------------------------------------------------------
module fsd_scaler (
   input  logic                          clock,
   input  logic                          reset,
   input  fsd_pkg::stage_ctl_type        ctl,
   input  fsd_pkg::parse_word_type       par_word,
   input  logic [fsd_pkg::SCALE_W-1:0]   scale,
   output logic                          out_valid,
   output fsd_pkg::rsp_word_type         out_word
);

   logic                               out_valid_ff;
   fsd_pkg::rsp_word_type              out_word_ff;
   logic [fsd_pkg::VALUE_W-1:0]        product;

   // 32 x 10 multiply
   assign product = {{fsd_pkg::SCALE_W{1'b0}}, par_word.flux_sum}
                  * {{fsd_pkg::SUM_W{1'b0}}, scale};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         out_valid_ff <= ctl.src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.src_valid) begin
         out_word_ff.flux_value <= product;
         out_word_ff.flux_valid <= par_word.flux_valid;
         out_word_ff.stream_end <= par_word.stream_end;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

// ===== sv/flux_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// flux_stream_decoder_unit
// Byte-serial flux capture stream decoder producing scaled flux intervals
// and end-of-stream marks.
// ----------------------------------------------------------------------------
// A result shows on rsp_valid from the result register once its byte leaves the input register.
// Throughput: one byte per cycle while the output is not stalled; the result
// register moves on when it is empty or draining, the input register also when empty.
// Reset: synchronous; clears all stage valids and the parse state, and sets
// the output scale to 1000.
module flux_stream_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fsd_pkg::req_word_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fsd_pkg::rsp_word_type  rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [9:0]             csr_data
);

   logic                          s0_valid_ff;
   fsd_pkg::req_word_type         s0_word_ff;
   logic [fsd_pkg::SCALE_W-1:0]   scale_ff;
   logic                          par_valid;
   fsd_pkg::parse_word_type       par_word;
   logic                          adv0, adv2;
   fsd_pkg::stage_ctl_type        parser_ctl, scaler_ctl;

   // stage advance chain
   assign adv2      = !rsp_valid || !rsp_stall;
   assign adv0      = !s0_valid_ff || adv2;
   assign req_stall = !adv0;
   assign csr_ready = 1'b1;

   assign parser_ctl = '{src_valid: s0_valid_ff, advance: adv2};
   assign scaler_ctl = '{src_valid: par_valid, advance: adv2};

   // scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= fsd_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv0) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0 && req_valid) begin
         s0_word_ff <= req_data;
      end
   end

   fsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctl       (parser_ctl),
      .byte_word (s0_word_ff),
      .par_valid (par_valid),
      .par_word  (par_word)
   );

   fsd_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scaler_ctl),
      .par_word  (par_word),
      .scale     (scale_ff),
      .out_valid (rsp_valid),
      .out_word  (rsp_data)
   );

`ifndef SYNTHESIS
   // every result word carries an interval or an end mark
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.flux_valid || rsp_data.stream_end))
      else $error("result word with neither interval nor end mark");

   // an end mark without interval has a zero value
   a_rsp_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.flux_valid) |-> (rsp_data.flux_value == '0))
      else $error("non-zero value without interval");

   // input stalls only while the input register is occupied and blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s0_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flux_stream_decoder_unit. Capture-stream bytes are
// pushed through the request channel, a behavioural decoder in the bench
// predicts each flux interval and end-of-stream mark, and every result word
// is checked field by field against the oldest prediction. A short directed
// table comes first, then random, mostly well-formed packet traffic under
// several output scales, with bursty input and a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  NOP1_CODE = 8'h08;            // single-byte nop
   localparam logic [31:0] OVF_STEP  = 32'h0001_0000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          SETTLE_CYCLES = 8;

   // one row of the directed table
   typedef struct packed {
      logic [7:0]  code;
      logic        last;
      logic        typed;
      logic [41:0] value;
      logic        valid;
      logic        is_end;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   fsd_pkg::req_word_type req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   fsd_pkg::rsp_word_type rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [9:0]            csr_data;

   // decoder state mirrored by the bench
   logic [9:0]          scale_cfg  = fsd_pkg::SCALE_RESET;
   fsd_pkg::phase_type  parse_ph   = fsd_pkg::PH_IDLE;
   logic [31:0]         ovf_total  = '0;
   logic [15:0]         held_byte  = '0;
   logic [16:0]         skip_left  = '0;
   logic [7:0]          oob_type   = '0;

   fsd_pkg::rsp_word_type pending_flux [$];
   int                    fail_count   = 0;
   int                    stream_items = 0;
   bit                    sender_gaps  = 1'b1;
   int                    burst_left   = 0;
   bit                    hold_request = 1'b0;
   dir_row_type           directed_rows [0:24];

   flux_stream_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[flux_stream_decoder_unit] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Behavioural decoder: one stream byte in, at most one result word out
   // ------------------------------------------------------------------------
   function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                      output fsd_pkg::rsp_word_type r);
      logic [15:0] raw;
      logic [15:0] oob_size;
      bit          got_flux;
      bit          got_end;
      raw      = '0;
      got_flux = 1'b0;
      got_end  = 1'b0;
      r        = '0;
      case (parse_ph)
         fsd_pkg::PH_F2_LOW: begin
            raw      = {5'd0, held_byte[2:0], b};
            got_flux = 1'b1;
            parse_ph = fsd_pkg::PH_IDLE;
         end
         fsd_pkg::PH_F3_HIGH: begin
            held_byte = {8'd0, b};
            parse_ph  = fsd_pkg::PH_F3_LOW;
         end
         fsd_pkg::PH_F3_LOW: begin
            raw      = {held_byte[7:0], b};
            got_flux = 1'b1;
            parse_ph = fsd_pkg::PH_IDLE;
         end
         fsd_pkg::PH_SKIP: begin
            if (skip_left != 0) skip_left = skip_left - 1'b1;
            if (skip_left == 0) parse_ph = fsd_pkg::PH_IDLE;
         end
         fsd_pkg::PH_OOB_TYPE: begin
            oob_type = b;
            parse_ph = fsd_pkg::PH_OOB_SZLO;
         end
         fsd_pkg::PH_OOB_SZLO: begin
            held_byte = {8'd0, b};
            parse_ph  = fsd_pkg::PH_OOB_SZHI;
         end
         fsd_pkg::PH_OOB_SZHI: begin
            // little-endian block size
            oob_size = {b, held_byte[7:0]};
            if (oob_type == fsd_pkg::OOB_END) begin
               got_end = 1'b1;
            end else if (oob_size == 0) begin
               parse_ph = fsd_pkg::PH_IDLE;
            end else begin
               skip_left = {1'b0, oob_size};
               parse_ph  = fsd_pkg::PH_SKIP;
            end
         end
         default: begin
            // packet header
            parse_ph = fsd_pkg::PH_IDLE;
            if (b <= fsd_pkg::HDR_FLUX2_MAX) begin
               held_byte = {8'd0, b};
               parse_ph  = fsd_pkg::PH_F2_LOW;
            end else if (b >= fsd_pkg::HDR_FLUX1_MIN) begin
               raw      = {8'd0, b};
               got_flux = 1'b1;
            end else if (b == fsd_pkg::HDR_NOP2) begin
               skip_left = 17'd1;
               parse_ph  = fsd_pkg::PH_SKIP;
            end else if (b == fsd_pkg::HDR_NOP3) begin
               skip_left = 17'd2;
               parse_ph  = fsd_pkg::PH_SKIP;
            end else if (b == fsd_pkg::HDR_OVF16) begin
               // saturates so the sum still fits 32 bits
               if (ovf_total >= {fsd_pkg::OVF_LIMIT, 16'h0000})
                  ovf_total = {fsd_pkg::OVF_LIMIT, 16'h0000};
               else
                  ovf_total = ovf_total + OVF_STEP;
            end else if (b == fsd_pkg::HDR_FLUX3) begin
               parse_ph = fsd_pkg::PH_F3_HIGH;
            end else if (b == fsd_pkg::HDR_OOB) begin
               parse_ph = fsd_pkg::PH_OOB_TYPE;
            end
         end
      endcase

      if (got_flux) begin
         r.flux_value = ({10'd0, ovf_total} + {26'd0, raw}) * {32'd0, scale_cfg};
         ovf_total    = '0;
      end
      if (last) got_end = 1'b1;
      // end of stream drops everything but the scale
      if (got_end) begin
         parse_ph  = fsd_pkg::PH_IDLE;
         ovf_total = '0;
         held_byte = '0;
         skip_left = '0;
         oob_type  = '0;
      end
      r.flux_valid = got_flux;
      r.stream_end = got_end;
      return got_flux || got_end;
   endfunction

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input logic [41:0] got,
                                  input logic [41:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // ------------------------------------------------------------------------
   // Sender: one byte per call; while sender_gaps is set, bursts with random gaps between them
   // ------------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] b, input logic last, input bit typed,
                           input fsd_pkg::rsp_word_type want);
      int                    gap;
      fsd_pkg::rsp_word_type got;
      bit                    has_word;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data  <= {b, last};
      do @(posedge clock); while (req_stall);
      // word taken at this edge
      has_word = decode_byte(b, last, got);
      if (typed)
         pending_flux.push_back(want);
      else if (has_word)
         pending_flux.push_back(got);
   endtask

   // stop sending and wait for every expected result, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_flux.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [9:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scale_cfg = v;
   endtask

   // one packet, mostly well formed; occasionally cut short or ended early
   task automatic random_packet();
      logic [7:0]  pkt [$];
      logic [7:0]  tmp;
      logic [15:0] sz;
      int          sel;
      int          n;
      bit          end_flag;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         tmp = 8'($urandom_range(fsd_pkg::HDR_FLUX1_MIN, 255));
         pkt.push_back(tmp);
      end else if (sel < 45) begin
         tmp = 8'($urandom_range(0, fsd_pkg::HDR_FLUX2_MAX));
         pkt.push_back(tmp);
         pkt.push_back(rnd_byte());
      end else if (sel < 58) begin
         pkt.push_back(fsd_pkg::HDR_FLUX3);
         pkt.push_back(rnd_byte());
         pkt.push_back(rnd_byte());
      end else if (sel < 64) begin
         pkt.push_back(NOP1_CODE);
      end else if (sel < 68) begin
         pkt.push_back(fsd_pkg::HDR_NOP2);
         pkt.push_back(rnd_byte());
      end else if (sel < 72) begin
         pkt.push_back(fsd_pkg::HDR_NOP3);
         pkt.push_back(rnd_byte());
         pkt.push_back(rnd_byte());
      end else if (sel < 82) begin
         pkt.push_back(fsd_pkg::HDR_OVF16);
      end else if (sel < 92) begin
         // out-of-band block, mostly short payloads
         tmp = ($urandom_range(0, 4) == 0) ? fsd_pkg::OOB_END : rnd_byte();
         n   = $urandom_range(0, 99);
         if (tmp == fsd_pkg::OOB_END) sz = 16'($urandom_range(0, 65535));
         else if (n < 70)             sz = 16'($urandom_range(0, 4));
         else if (n < 95)             sz = 16'($urandom_range(0, 40));
         else                         sz = 16'($urandom_range(256, 300));
         pkt.push_back(fsd_pkg::HDR_OOB);
         pkt.push_back(tmp);
         pkt.push_back(sz[7:0]);
         pkt.push_back(sz[15:8]);
      end else begin
         pkt.push_back(rnd_byte());
      end
      if (sel >= 82 && sel < 92 && pkt[1] != fsd_pkg::OOB_END)
         repeat (sz) pkt.push_back(rnd_byte());

      n        = pkt.size();
      end_flag = 1'b0;
      if (n > 1 && $urandom_range(0, 99) < 5) begin
         n        = $urandom_range(1, n - 1);
         end_flag = 1'b1;
      end else if ($urandom_range(0, 99) < 4) begin
         end_flag = 1'b1;
      end
      for (int i = 0; i < n; i++)
         put_byte(pkt[i], end_flag && (i == n - 1), 1'b0, '0);
      // every byte sent counts, skipped payload included
      stream_items += n;
   endtask

   task automatic run_random(input int count);
      int start;
      start = stream_items;
      while (stream_items - start < count) random_packet();
   endtask

   // ------------------------------------------------------------------------
   // Receiver: own stall pattern, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int mode_left;
      int run_left;
      int stall_mode;
      bit level;
      hold_left  = 0;
      mode_left  = 0;
      run_left   = 0;
      stall_mode = 0;
      level      = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(100, 400);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall   <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 75);
               default: begin
                  // long runs of stall and no stall
                  if (run_left == 0) begin
                     level    = ~level;
                     run_left = $urandom_range(1, 20);
                  end
                  run_left--;
                  rsp_stall <= level;
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      fsd_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_flux.size() == 0) begin
            report_mismatch("unexpected result word", rsp_data.flux_value, '0);
         end else begin
            want = pending_flux.pop_front();
            if (rsp_data.flux_value !== want.flux_value)
               report_mismatch("flux_value", rsp_data.flux_value, want.flux_value);
            if (rsp_data.flux_valid !== want.flux_valid)
               report_mismatch("flux_valid", 42'(rsp_data.flux_valid),
                               42'(want.flux_valid));
            if (rsp_data.stream_end !== want.stream_end)
               report_mismatch("stream_end", 42'(rsp_data.stream_end),
                               42'(want.stream_end));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      dir_row_type           row;
      fsd_pkg::rsp_word_type want;
      logic [7:0]            tmp;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;

      // expected words typed in where plain from the format (scale 1000)
      directed_rows = '{
         '{fsd_pkg::HDR_FLUX1_MIN, 1'b0, 1'b1, 42'd14000,     1'b1, 1'b0},  // smallest 1-byte
         '{NOP1_CODE,              1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{fsd_pkg::HDR_FLUX2_MAX, 1'b0, 1'b0, 42'd0,         1'b0, 1'b0},  // largest 2-byte
         '{8'hFF,                  1'b0, 1'b1, 42'd2047000,   1'b1, 1'b0},
         '{fsd_pkg::HDR_NOP2,      1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'hAA,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{fsd_pkg::HDR_NOP3,      1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'h55,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'h33,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{fsd_pkg::HDR_OVF16,     1'b0, 1'b0, 42'd0,         1'b0, 1'b0},  // overflow, then
         '{fsd_pkg::HDR_FLUX3,     1'b0, 1'b0, 42'd0,         1'b0, 1'b0},  // largest 3-byte
         '{8'hFF,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'hFF,                  1'b0, 1'b1, 42'd131071000, 1'b1, 1'b0},
         '{fsd_pkg::HDR_OOB,       1'b0, 1'b0, 42'd0,         1'b0, 1'b0},  // OOB, 1 byte
         '{8'h01,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'h01,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'h00,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'hFF,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{fsd_pkg::HDR_OOB,       1'b0, 1'b0, 42'd0,         1'b0, 1'b0},  // end block
         '{fsd_pkg::OOB_END,       1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'h00,                  1'b0, 1'b0, 42'd0,         1'b0, 1'b0},
         '{8'h00,                  1'b0, 1'b1, 42'd0,         1'b0, 1'b1},
         '{fsd_pkg::HDR_FLUX3,     1'b0, 1'b0, 42'd0,         1'b0, 1'b0},  // cut by last
         '{8'h12,                  1'b1, 1'b1, 42'd0,         1'b0, 1'b1},
         '{8'hFF,                  1'b1, 1'b1, 42'd255000,    1'b1, 1'b1}   // flux on last
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row  = directed_rows[i];
         want = '{flux_value: row.value, flux_valid: row.valid, stream_end: row.is_end};
         put_byte(row.code, row.last, row.typed, want);
      end

      write_scale(10'd1);
      run_random(190);

      // receiver holds off while the sender keeps pushing flux words
      write_scale(10'd1023);
      sender_gaps  = 1'b0;
      hold_request = 1'b1;
      repeat (40) begin
         tmp = 8'($urandom_range(fsd_pkg::HDR_FLUX1_MIN, 255));
         put_byte(tmp, 1'b0, 1'b0, '0);
      end
      run_random(180);

      // several overflow words ahead of a flux
      repeat (3) put_byte(fsd_pkg::HDR_OVF16, 1'b0, 1'b0, '0);
      put_byte(8'hFF, 1'b0, 1'b0, '0);
      put_byte(fsd_pkg::HDR_OVF16, 1'b0, 1'b0, '0);
      put_byte(fsd_pkg::HDR_FLUX1_MIN, 1'b0, 1'b0, '0);

      // sender waits for every outstanding result before going on
      settle();
      sender_gaps = 1'b1;
      run_random(150);

      write_scale(10'($urandom_range(2, 1022)));
      run_random(200);

      write_scale(10'd512);
      sender_gaps = 1'b0;
      run_random(110);
      sender_gaps = 1'b1;
      run_random(150);

      settle();
      if (fail_count == 0)
         $display("[flux_stream_decoder_unit] OK");
      else
         $display("[flux_stream_decoder_unit] ERROR");
      $finish;
   end

endmodule
